>>> hdl/hsvba_pkg.sv
`default_nettype none
package hsvba_pkg;

  localparam int CHAN_W     = 8;
  localparam int GAIN_FRAC  = 8;
  localparam int GAIN_W     = GAIN_FRAC + 4;
  localparam int SAT_W      = 17;
  localparam int HUE_W      = 11;
  localparam int XF_W       = 9;
  localparam int DIV_STAGES = 9;
  localparam int QUO_W      = 2 * DIV_STAGES;
  localparam int CFG_IDX_W  = 2;

  localparam logic [GAIN_W-1:0] GAIN_UNITY = GAIN_W'(1 << GAIN_FRAC);
  localparam logic [SAT_W-1:0]  SAT_ONE    = SAT_W'(1 << 16);
  localparam logic [HUE_W-1:0]  HUE_FULL   = HUE_W'(1536);
  localparam logic [HUE_W-1:0]  HUE_GREEN  = HUE_W'(512);
  localparam logic [HUE_W-1:0]  HUE_BLUE   = HUE_W'(1024);

  localparam logic [CFG_IDX_W-1:0] REG_BRIGHTNESS_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SATURATION_GAIN = 2'd1;

  localparam logic [1:0] HSEL_RED   = 2'd0;
  localparam logic [1:0] HSEL_GREEN = 2'd1;
  localparam logic [1:0] HSEL_BLUE  = 2'd2;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
  } pix_out_t;

endpackage
`default_nettype wire

>>> hdl/hsvba_div.sv
`default_nettype none
module hsvba_div (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [hsvba_pkg::CHAN_W-1:0]    num,
  input  wire logic [hsvba_pkg::CHAN_W-1:0]    den,
  output      logic [hsvba_pkg::QUO_W-1:0]     quo
);

  typedef struct packed {
    logic [hsvba_pkg::CHAN_W-1:0] rem;
    logic [hsvba_pkg::CHAN_W-1:0] den;
    logic [hsvba_pkg::QUO_W-1:0]  quo;
  } div_stage_t;

  div_stage_t stg_r   [hsvba_pkg::DIV_STAGES];
  div_stage_t stg_nxt [hsvba_pkg::DIV_STAGES];
  div_stage_t src     [hsvba_pkg::DIV_STAGES];

  function automatic logic [hsvba_pkg::CHAN_W:0] div_step(
    input logic [hsvba_pkg::CHAN_W:0]   v,
    input logic [hsvba_pkg::CHAN_W-1:0] d
  );
    logic                          ge;
    logic [hsvba_pkg::CHAN_W:0]    diff;
    ge   = v >= {1'b0, d};
    diff = v - {1'b0, d};
    return {ge, ge ? diff[hsvba_pkg::CHAN_W-1:0] : v[hsvba_pkg::CHAN_W-1:0]};
  endfunction

  for (genvar k = 0; k < hsvba_pkg::DIV_STAGES; k++) begin : g_stg
    logic [hsvba_pkg::CHAN_W:0] s0;
    logic [hsvba_pkg::CHAN_W:0] s1;

    if (k == 0) begin : g_first
      assign src[k] = '{rem: num, den: den, quo: '0};
      assign s0 = div_step({1'b0, src[k].rem}, src[k].den);
    end else begin : g_rest
      assign src[k] = stg_r[k-1];
      assign s0 = div_step({src[k].rem, 1'b0}, src[k].den);
    end

    always_comb begin
      s1 = div_step({s0[hsvba_pkg::CHAN_W-1:0], 1'b0}, src[k].den);
      stg_nxt[k] = '{rem: s1[hsvba_pkg::CHAN_W-1:0], den: src[k].den,
                     quo: {src[k].quo[hsvba_pkg::QUO_W-3:0],
                           s0[hsvba_pkg::CHAN_W], s1[hsvba_pkg::CHAN_W]}};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  assign quo = stg_r[hsvba_pkg::DIV_STAGES-1].quo;

endmodule
`default_nettype wire

>>> hdl/hsv_brightness_saturation_adjust.sv
// Throughput: one pixel per cycle while the skid is empty; the two 18-step divider pipelines set the depth.
// A two-entry output register and skid stage keep in_ready registered.
// Reset (rst_n low, synchronous): all valid bits and the skid clear, both gains
// return to unity (256).
`default_nettype none
module hsv_brightness_saturation_adjust (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire hsvba_pkg::pix_in_t                   in_data,
  output      logic                                 out_valid,
  input  wire logic                                 out_ready,
  output      hsvba_pkg::pix_out_t                  out_data,
  input  wire logic                                 cfg_valid,
  output      logic                                 cfg_ready,
  input  wire logic [hsvba_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [hsvba_pkg::GAIN_W-1:0]         cfg_data
);

  typedef struct packed {
    logic [hsvba_pkg::CHAN_W-1:0] alpha;
    logic [hsvba_pkg::CHAN_W-1:0] mx;
    logic [1:0]                   sel;
    logic                         neg;
    logic                         gray;
  } side_t;

  logic en;
  logic [hsvba_pkg::GAIN_W-1:0] bgain_r, sgain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bgain_r <= hsvba_pkg::GAIN_UNITY;
      sgain_r <= hsvba_pkg::GAIN_UNITY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        hsvba_pkg::REG_BRIGHTNESS_GAIN: bgain_r <= cfg_data;
        hsvba_pkg::REG_SATURATION_GAIN: sgain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  logic               v0_r;
  hsvba_pkg::pix_in_t in_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r <= in_data;
    end
  end

  // max, min, delta, hue sector select
  logic [hsvba_pkg::CHAN_W-1:0] mx, mn, delta, mag;
  logic [hsvba_pkg::CHAN_W:0]   hnum;
  logic [1:0]                   sel;
  side_t                        side_nxt;

  always_comb begin
    mx = in_r.red_in;
    mn = in_r.red_in;
    if (in_r.green_in > mx) mx = in_r.green_in;
    if (in_r.blue_in > mx)  mx = in_r.blue_in;
    if (in_r.green_in < mn) mn = in_r.green_in;
    if (in_r.blue_in < mn)  mn = in_r.blue_in;
    delta = mx - mn;
    if (mx == in_r.red_in) begin
      sel  = hsvba_pkg::HSEL_RED;
      hnum = {1'b0, in_r.green_in} - {1'b0, in_r.blue_in};
    end else if (mx == in_r.green_in) begin
      sel  = hsvba_pkg::HSEL_GREEN;
      hnum = {1'b0, in_r.blue_in} - {1'b0, in_r.red_in};
    end else begin
      sel  = hsvba_pkg::HSEL_BLUE;
      hnum = {1'b0, in_r.red_in} - {1'b0, in_r.green_in};
    end
    mag = hnum[hsvba_pkg::CHAN_W] ? hsvba_pkg::CHAN_W'(-hnum)
                                  : hnum[hsvba_pkg::CHAN_W-1:0];
    side_nxt = '{alpha: in_r.alpha_in, mx: mx, sel: sel,
                 neg: hnum[hsvba_pkg::CHAN_W], gray: (delta == '0)};
  end

  logic                          v1_r;
  side_t                         side1_r;
  logic [hsvba_pkg::CHAN_W-1:0]  sat_num_r, sat_den_r, hue_num_r, hue_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r   <= side_nxt;
      sat_num_r <= delta;
      sat_den_r <= (mx == '0) ? hsvba_pkg::CHAN_W'(1) : mx;
      hue_num_r <= (delta == '0) ? '0 : mag;
      hue_den_r <= (delta == '0) ? hsvba_pkg::CHAN_W'(1) : delta;
    end
  end

  // dividers and matching side delay line
  logic [hsvba_pkg::QUO_W-1:0] sat_quo, hue_quo;

  hsvba_div u_sat_div (
    .clk (clk),
    .en  (en),
    .num (sat_num_r),
    .den (sat_den_r),
    .quo (sat_quo)
  );

  hsvba_div u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hue_num_r),
    .den (hue_den_r),
    .quo (hue_quo)
  );

  logic  vd_r   [hsvba_pkg::DIV_STAGES];
  side_t sided_r [hsvba_pkg::DIV_STAGES];

  for (genvar k = 0; k < hsvba_pkg::DIV_STAGES; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vd_r[k] <= 1'b0;
      end else if (en) begin
        vd_r[k] <= (k == 0) ? v1_r : vd_r[(k == 0) ? 0 : k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sided_r[k] <= (k == 0) ? side1_r : sided_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  side_t sd;
  assign sd = sided_r[hsvba_pkg::DIV_STAGES-1];

  // stage A: round quotients, hue, gains
  logic [hsvba_pkg::QUO_W:0]      sat_sum;
  logic [hsvba_pkg::SAT_W-1:0]    sat;
  logic [10:0]                    part_sum;
  logic [hsvba_pkg::XF_W-1:0]     part;
  logic [hsvba_pkg::HUE_W-1:0]    part_w, hue_nxt;
  logic [19:0]                    vprod;
  logic [11:0]                    vround;
  logic [28:0]                    sprod;
  logic [20:0]                    sround;
  logic [hsvba_pkg::CHAN_W-1:0]   val_nxt;
  logic [hsvba_pkg::SAT_W-1:0]    satg_nxt;

  always_comb begin
    sat_sum  = {1'b0, sat_quo} + (hsvba_pkg::QUO_W+1)'(1);
    sat      = sat_sum[hsvba_pkg::SAT_W:1];
    part_sum = {1'b0, hue_quo[hsvba_pkg::QUO_W-1:8]} + 11'd1;
    part     = part_sum[9:1];
    part_w   = {2'b00, part};
    hue_nxt  = '0;
    if (!sd.gray) begin
      case (sd.sel)
        hsvba_pkg::HSEL_RED:
          hue_nxt = (sd.neg && part != '0) ? hsvba_pkg::HUE_FULL - part_w : part_w;
        hsvba_pkg::HSEL_GREEN:
          hue_nxt = sd.neg ? hsvba_pkg::HUE_GREEN - part_w : hsvba_pkg::HUE_GREEN + part_w;
        default:
          hue_nxt = sd.neg ? hsvba_pkg::HUE_BLUE - part_w : hsvba_pkg::HUE_BLUE + part_w;
      endcase
    end
    vprod    = {12'b0, sd.mx} * {8'b0, bgain_r};
    vround   = 12'((vprod + 20'd128) >> hsvba_pkg::GAIN_FRAC);
    val_nxt  = (vround > 12'd255) ? 8'd255 : vround[7:0];
    sprod    = {12'b0, sat} * {17'b0, sgain_r};
    sround   = 21'((sprod + 29'd128) >> hsvba_pkg::GAIN_FRAC);
    satg_nxt = (sround > {4'b0, hsvba_pkg::SAT_ONE}) ? hsvba_pkg::SAT_ONE
                                                      : sround[hsvba_pkg::SAT_W-1:0];
  end

  logic                          va_r;
  logic [hsvba_pkg::HUE_W-1:0]   hue_a_r;
  logic [hsvba_pkg::CHAN_W-1:0]  val_a_r, alpha_a_r;
  logic [hsvba_pkg::SAT_W-1:0]   sat_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= vd_r[hsvba_pkg::DIV_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hue_a_r   <= hue_nxt;
      val_a_r   <= val_nxt;
      sat_a_r   <= satg_nxt;
      alpha_a_r <= sd.alpha;
    end
  end

  // stage B: sector, ramp, val * sat
  logic [2:0]                  sector_nxt;
  logic [hsvba_pkg::XF_W-1:0]  xf_nxt;
  logic [24:0]                 vs_nxt;

  always_comb begin
    sector_nxt = (hue_a_r[10:8] > 3'd5) ? 3'd5 : hue_a_r[10:8];
    xf_nxt     = sector_nxt[0] ? 9'd256 - {1'b0, hue_a_r[7:0]} : {1'b0, hue_a_r[7:0]};
    vs_nxt     = {17'b0, val_a_r} * {8'b0, sat_a_r};
  end

  logic                          vb_r;
  logic [2:0]                    sector_b_r;
  logic [hsvba_pkg::XF_W-1:0]    xf_b_r;
  logic [24:0]                   vs_b_r;
  logic [hsvba_pkg::CHAN_W-1:0]  val_b_r, alpha_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector_b_r <= sector_nxt;
      xf_b_r     <= xf_nxt;
      vs_b_r     <= vs_nxt;
      val_b_r    <= val_a_r;
      alpha_b_r  <= alpha_a_r;
    end
  end

  // stage C: ramp product and offset
  logic [33:0] x_nxt;
  logic [32:0] vsh_nxt, m_nxt;

  always_comb begin
    x_nxt   = {9'b0, vs_b_r} * {25'b0, xf_b_r};
    vsh_nxt = {vs_b_r, 8'b0};
    m_nxt   = {1'b0, val_b_r, 24'b0} - vsh_nxt;
  end

  logic                          vc_r;
  logic [2:0]                    sector_c_r;
  logic [33:0]                   x_c_r;
  logic [32:0]                   vsh_c_r, m_c_r;
  logic [hsvba_pkg::CHAN_W-1:0]  alpha_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sector_c_r <= sector_b_r;
      x_c_r      <= x_nxt;
      vsh_c_r    <= vsh_nxt;
      m_c_r      <= m_nxt;
      alpha_c_r  <= alpha_b_r;
    end
  end

  // stage D: assemble channels, round, clamp
  logic [33:0] comp [3];
  logic [33:0] vsw;
  logic [7:0]  chan [3];

  always_comb begin
    vsw = {1'b0, vsh_c_r};
    case (sector_c_r)
      3'd0:    begin comp[0] = vsw;   comp[1] = x_c_r; comp[2] = '0;    end
      3'd1:    begin comp[0] = x_c_r; comp[1] = vsw;   comp[2] = '0;    end
      3'd2:    begin comp[0] = '0;    comp[1] = vsw;   comp[2] = x_c_r; end
      3'd3:    begin comp[0] = '0;    comp[1] = x_c_r; comp[2] = vsw;   end
      3'd4:    begin comp[0] = x_c_r; comp[1] = '0;    comp[2] = vsw;   end
      default: begin comp[0] = vsw;   comp[1] = '0;    comp[2] = x_c_r; end
    endcase
  end

  for (genvar i = 0; i < 3; i++) begin : g_chan
    logic [34:0] csum;
    always_comb begin
      csum    = {1'b0, comp[i]} + {2'b0, m_c_r} + 35'(1 << 23);
      chan[i] = (csum[34:24] > 11'd255) ? 8'd255 : csum[31:24];
    end
  end

  logic                 vd_out_r;
  hsvba_pkg::pix_out_t  pd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_out_r <= 1'b0;
    end else if (en) begin
      vd_out_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pd_r <= '{red_out: chan[0], green_out: chan[1], blue_out: chan[2],
                alpha_out: alpha_c_r};
    end
  end

  // output register and skid
  logic                 out_valid_r, skid_valid_r, push;
  hsvba_pkg::pix_out_t  out_r, skid_r;

  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign push     = en && vd_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
        out_valid_r  <= 1'b1;
      end else begin
        out_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_r <= skid_valid_r ? skid_r : pd_r;
    end else if (push) begin
      skid_r <= pd_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a request while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !out_ready) |=> skid_valid_r)
    else $error("skid request dropped during stall");

  a_skid_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (!skid_valid_r && out_valid_r && !out_ready && vd_out_r) |=> skid_valid_r)
    else $error("stalled request not caught by skid");

endmodule
`default_nettype wire

>>> tb/hsv_brightness_saturation_adjust_tb.sv
`default_nettype none
module hsv_brightness_saturation_adjust_tb;
  import hsvba_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pix_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  pix_in_t pixel_q[$];
  pix_out_t adjusted_q[$];
  logic [GAIN_W-1:0] bright_gain = GAIN_UNITY;
  logic [GAIN_W-1:0] sat_gain = GAIN_UNITY;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit in_took = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int mismatches = 0;
  int pixels_sent = 0;
  int pixels_checked = 0;
  int cfg_writes = 0;

  hsv_brightness_saturation_adjust i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic longint hue_step(longint num, longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (512 * mag + den) / (2 * den);
    return (num < 0) ? -q : q;
  endfunction

  function automatic pix_out_t adjust_pixel(pix_in_t p);
    longint r, g, b, mx, mn, delta, hue, sat, val, vs, x, m, sector, frac, xf, c;
    longint comp[3];
    pix_out_t o;
    r = p.red_in;
    g = p.green_in;
    b = p.blue_in;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    sat = 0;
    hue = 0;
    if (mx != 0) sat = (delta * 2 * 65536 + mx) / (2 * mx);
    if (delta != 0) begin
      if (mx == r) begin
        hue = hue_step(g - b, delta);
        if (hue < 0) hue += 1536;
      end else if (mx == g) begin
        hue = hue_step(b - r, delta) + 512;
      end else begin
        hue = hue_step(r - g, delta) + 1024;
      end
    end
    val = (mx * longint'(bright_gain) + 128) >>> 8;
    if (val > 255) val = 255;
    sat = (sat * longint'(sat_gain) + 128) >>> 8;
    if (sat > 65536) sat = 65536;
    sector = hue / 256;
    if (sector > 5) sector = 5;
    frac = hue % 256;
    xf = sector[0] ? (256 - frac) : frac;
    vs = val * sat;
    x = vs * xf;
    m = (val <<< 24) - (vs <<< 8);
    vs = vs <<< 8;
    case (sector)
      0: begin comp[0] = vs; comp[1] = x;  comp[2] = 0;  end
      1: begin comp[0] = x;  comp[1] = vs; comp[2] = 0;  end
      2: begin comp[0] = 0;  comp[1] = vs; comp[2] = x;  end
      3: begin comp[0] = 0;  comp[1] = x;  comp[2] = vs; end
      4: begin comp[0] = x;  comp[1] = 0;  comp[2] = vs; end
      default: begin comp[0] = vs; comp[1] = 0; comp[2] = x; end
    endcase
    for (int i = 0; i < 3; i++) begin
      c = (comp[i] + m + (longint'(1) <<< 23)) >>> 24;
      if (c > 255) c = 255;
      comp[i] = c;
    end
    o.red_out = comp[0][7:0];
    o.green_out = comp[1][7:0];
    o.blue_out = comp[2][7:0];
    o.alpha_out = p.alpha_in;
    return o;
  endfunction

  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || in_took) begin
        if (pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= pixel_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_left = 400;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pix_out_t want;
    in_took = rst_n && in_valid && in_ready;
    if (in_took) adjusted_q.push_back(adjust_pixel(in_data));
    if (rst_n && out_valid && out_ready) begin
      if (adjusted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel %h", out_data);
      end else begin
        want = adjusted_q.pop_front();
        pixels_checked++;
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel %0d: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                     pixels_checked, want.red_out, want.green_out, want.blue_out,
                     want.alpha_out, out_data.red_out, out_data.green_out,
                     out_data.blue_out, out_data.alpha_out);
        end
      end
    end
  end

  task automatic queue_pixel(int r, int g, int b, int a);
    pix_in_t p;
    p.red_in = r[7:0];
    p.green_in = g[7:0];
    p.blue_in = b[7:0];
    p.alpha_in = a[7:0];
    pixel_q.push_back(p);
    pixels_sent++;
  endtask

  task automatic queue_random_pixel();
    int r, g, b, a;
    r = $urandom_range(255);
    g = $urandom_range(255);
    b = $urandom_range(255);
    a = $urandom_range(255);
    case ($urandom_range(9))
      0: begin g = r; b = r; end
      1: g = r;
      2: b = g;
      3: b = r;
      4: begin r = 0; g = 0; b = 0; end
      5: begin
        r = $urandom_range(1) * 255;
        g = $urandom_range(1) * 255;
        b = $urandom_range(1) * 255;
      end
      default: ;
    endcase
    queue_pixel(r, g, b, a);
  endtask

  task automatic drain();
    while (pixel_q.size() > 0 || in_valid || adjusted_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[GAIN_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BRIGHTNESS_GAIN) bright_gain = value[GAIN_W-1:0];
    else if (idx == REG_SATURATION_GAIN) sat_gain = value[GAIN_W-1:0];
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int gains[8][2];
    gains = '{'{256, 256}, '{0, 0}, '{4095, 4095}, '{0, 4095},
              '{4095, 0}, '{128, 512}, '{384, 100}, '{-1, -1}};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    queue_pixel(0, 0, 0, 0);
    queue_pixel(255, 255, 255, 255);
    queue_pixel(128, 128, 128, 77);
    queue_pixel(255, 0, 0, 1);
    queue_pixel(0, 255, 0, 2);
    queue_pixel(0, 0, 255, 3);
    queue_pixel(200, 200, 10, 4);
    queue_pixel(10, 200, 200, 5);
    queue_pixel(200, 10, 200, 6);
    queue_pixel(255, 10, 200, 7);
    queue_pixel(255, 200, 10, 8);
    queue_pixel(10, 255, 200, 9);
    queue_pixel(200, 10, 255, 10);
    queue_pixel(1, 0, 0, 128);
    queue_pixel(255, 254, 0, 200);
    queue_pixel(85, 170, 255, 170);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      if (gains[ph][0] < 0) begin
        gains[ph][0] = $urandom_range(4095);
        gains[ph][1] = $urandom_range(4095);
      end
      write_reg(REG_BRIGHTNESS_GAIN, gains[ph][0]);
      write_reg(REG_SATURATION_GAIN, gains[ph][1]);
      write_reg(2'd2, $urandom_range(4095));
      write_reg(2'd3, $urandom_range(4095));
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < 105; n++) queue_random_pixel();
      drain();
      for (int n = 0; n < 105; n++) queue_random_pixel();
      drain();
    end

    $display("%0d pixels checked over %0d register writes, gains from 0 to full scale,",
             pixels_checked, cfg_writes);
    $display("with gray, black, tied and saturated colours under varied flow control");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad pixels", mismatches);
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout");
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

>>> sim.f
hdl/hsvba_pkg.sv
hdl/hsvba_div.sv
hdl/hsv_brightness_saturation_adjust.sv
tb/hsv_brightness_saturation_adjust_tb.sv
